// ===== design/mke_pkg.sv =====
`timescale 1ns / 1ps
package mke_pkg;

    localparam int NPC = 12;
    localparam int FIELD_W = 24;
    localparam int CHROMA_BITS_DEF = 24;
    localparam int W_BITS = 14;
    localparam int K_W = 25;
    localparam int PART_W = 30;
    localparam int KEY_W = 4;
    localparam int TONIC_W = 13;
    localparam int CFG_W = 24;

    localparam logic REG_MIN_TOTAL = 1'b0;

    localparam logic signed [W_BITS-1:0] MAJ_W [NPC] = '{
        14'sd3441, -14'sd1503, -14'sd3, -14'sd1383, 14'sd1077, 14'sd729,
        -14'sd1155, 14'sd2049, -14'sd1311, 14'sd213, -14'sd1431, -14'sd723};
    localparam logic signed [W_BITS-1:0] MIN_W [NPC] = '{
        14'sd3145, -14'sd1235, -14'sd227, 14'sd2005, -14'sd1331, -14'sd215,
        -14'sd1403, 14'sd1249, 14'sd325, -14'sd1223, -14'sd443, -14'sd647};

    localparam logic [TONIC_W-1:0] TONIC [NPC] = '{
        13'd6541, 13'd6930, 13'd3671, 13'd3889, 13'd4120, 13'd4365,
        13'd4625, 13'd4900, 13'd5191, 13'd5500, 13'd5827, 13'd6174};

    // Sum of squared centered weights of one profile.
    function automatic logic [K_W-1:0] f_wsum(input logic minor);
        int s;
        int w;
        s = 0;
        for (int j = 0; j < NPC; j++) begin
            w = minor ? int'(MIN_W[j]) : int'(MAJ_W[j]);
            s = s + w * w;
        end
        return K_W'(s);
    endfunction

    localparam logic [K_W-1:0] K_MAJ = f_wsum(1'b0);
    localparam logic [K_W-1:0] K_MIN = f_wsum(1'b1);

    function automatic logic [TONIC_W-1:0] f_tonic(input logic [KEY_W-1:0] key);
        if (key < KEY_W'(NPC)) begin
            return TONIC[key];
        end
        return '0;
    endfunction

    typedef struct packed {
        logic [KEY_W-1:0] idx_maj;
        logic [KEY_W-1:0] idx_min;
        logic             neg_maj;
        logic             zero_maj;
        logic             neg_min;
        logic             zero_min;
    } t_meta;

endpackage

// ===== design/mke_lane.sv =====
`timescale 1ns / 1ps
module mke_lane #(
    parameter int XB = 24,
    parameter int N = 38,
    parameter int ROT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [XB-1:0]        i_x [mke_pkg::NPC],
    output logic signed [N-1:0]  o_nmaj,
    output logic signed [N-1:0]  o_nmin
);

    logic signed [N-1:0] n_nmaj;
    logic signed [N-1:0] n_nmin;
    logic signed [N-1:0] r_nmaj;
    logic signed [N-1:0] r_nmin;

    // Dot products of the rotated chroma with both centered profiles.
    always_comb begin
        n_nmaj = '0;
        n_nmin = '0;
        for (int j = 0; j < mke_pkg::NPC; j++) begin
            n_nmaj = n_nmaj + $signed({{(N-XB){1'b0}}, i_x[(j + ROT) % mke_pkg::NPC]})
                     * $signed({{(N-mke_pkg::W_BITS){mke_pkg::MAJ_W[j][mke_pkg::W_BITS-1]}},
                                mke_pkg::MAJ_W[j]});
            n_nmin = n_nmin + $signed({{(N-XB){1'b0}}, i_x[(j + ROT) % mke_pkg::NPC]})
                     * $signed({{(N-mke_pkg::W_BITS){mke_pkg::MIN_W[j][mke_pkg::W_BITS-1]}},
                                mke_pkg::MIN_W[j]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nmaj <= n_nmaj;
            r_nmin <= n_nmin;
        end
    end

    assign o_nmaj = r_nmaj;
    assign o_nmin = r_nmin;

endmodule

// ===== design/mke_merge.sv =====
`timescale 1ns / 1ps
module mke_merge #(
    parameter int N = 38
) (
    input  logic                          i_clk,
    input  logic [1:0]                    i_en,
    input  logic signed [N-1:0]           i_nmaj [mke_pkg::NPC],
    input  logic signed [N-1:0]           i_nmin [mke_pkg::NPC],
    output logic signed [N-1:0]           o_nmaj,
    output logic signed [N-1:0]           o_nmin,
    output logic [mke_pkg::KEY_W-1:0]     o_imaj,
    output logic [mke_pkg::KEY_W-1:0]     o_imin
);

    localparam int NG = mke_pkg::NPC / 4;

    logic signed [N-1:0]              n_n2 [2][NG];
    logic [mke_pkg::KEY_W-1:0]        n_i2 [2][NG];
    logic signed [N-1:0]              r_n2 [2][NG];
    logic [mke_pkg::KEY_W-1:0]        r_i2 [2][NG];
    logic signed [N-1:0]              n_n3 [2];
    logic [mke_pkg::KEY_W-1:0]        n_i3 [2];
    logic signed [N-1:0]              r_n3 [2];
    logic [mke_pkg::KEY_W-1:0]        r_i3 [2];

    // First level: best of each group of four. On a tie the lower rotation stays.
    always_comb begin
        logic signed [N-1:0]       a;
        logic signed [N-1:0]       b;
        logic signed [N-1:0]       c;
        logic signed [N-1:0]       d;
        logic [mke_pkg::KEY_W-1:0] ia;
        logic [mke_pkg::KEY_W-1:0] ic;
        for (int p = 0; p < 2; p++) begin
            for (int g = 0; g < NG; g++) begin
                a = (p == 0) ? i_nmaj[4*g]   : i_nmin[4*g];
                b = (p == 0) ? i_nmaj[4*g+1] : i_nmin[4*g+1];
                c = (p == 0) ? i_nmaj[4*g+2] : i_nmin[4*g+2];
                d = (p == 0) ? i_nmaj[4*g+3] : i_nmin[4*g+3];
                ia = mke_pkg::KEY_W'(4*g);
                ic = mke_pkg::KEY_W'(4*g+2);
                if (b > a) begin
                    a = b;
                    ia = mke_pkg::KEY_W'(4*g+1);
                end
                if (d > c) begin
                    c = d;
                    ic = mke_pkg::KEY_W'(4*g+3);
                end
                if (c > a) begin
                    a = c;
                    ia = ic;
                end
                n_n2[p][g] = a;
                n_i2[p][g] = ia;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_n2 <= n_n2;
            r_i2 <= n_i2;
        end
    end

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            n_n3[p] = r_n2[p][0];
            n_i3[p] = r_i2[p][0];
            for (int g = 1; g < NG; g++) begin
                if (r_n2[p][g] > n_n3[p]) begin
                    n_n3[p] = r_n2[p][g];
                    n_i3[p] = r_i2[p][g];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_n3 <= n_n3;
            r_i3 <= n_i3;
        end
    end

    assign o_nmaj = r_n3[0];
    assign o_nmin = r_n3[1];
    assign o_imaj = r_i3[0];
    assign o_imin = r_i3[1];

endmodule

// ===== design/mke_sqk.sv =====
`timescale 1ns / 1ps
module mke_sqk #(
    parameter int M = 37,
    parameter logic [mke_pkg::K_W-1:0] K = '0,
    parameter int OW = ((2*M + mke_pkg::PART_W - 1) / mke_pkg::PART_W) * mke_pkg::PART_W
                       + mke_pkg::K_W
) (
    input  logic          i_clk,
    input  logic [3:0]    i_en,
    input  logic [M-1:0]  i_mag,
    output logic [OW-1:0] o_val
);

    localparam int L = (M + 1) / 2;
    localparam int H = M - L;
    localparam int SQW = 2 * M;
    localparam int C = mke_pkg::PART_W;
    localparam int NC = (SQW + C - 1) / C;
    localparam int PW = C + mke_pkg::K_W;

    logic [2*L-1:0] r_ll;
    logic [L+H-1:0] r_lh;
    logic [2*H-1:0] r_hh;
    logic [SQW-1:0] r_sq;
    logic [NC*C-1:0] w_sqp;
    logic [PW-1:0]  r_prod [NC];
    logic [OW-1:0]  n_val;
    logic [OW-1:0]  r_val;

    // Square split into half-width partial products.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ll <= i_mag[L-1:0] * i_mag[L-1:0];
            r_lh <= i_mag[M-1:L] * i_mag[L-1:0];
            r_hh <= i_mag[M-1:L] * i_mag[M-1:L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_sq <= {r_hh, r_ll} + (SQW'(r_lh) << (L + 1));
        end
    end

    assign w_sqp = (NC*C)'(r_sq);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int i = 0; i < NC; i++) begin
                r_prod[i] <= w_sqp[i*C +: C] * K;
            end
        end
    end

    always_comb begin
        n_val = '0;
        for (int i = 0; i < NC; i++) begin
            n_val = n_val + (OW'(r_prod[i]) << (C * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

// ===== design/musical_key_estimator_unit.sv =====
`timescale 1ns / 1ps
// An accepted word reaches o_valid through the input, lane, merge, square and result registers.
// Throughput: one chroma word per cycle unless i_ready stalls; twelve rotation lanes work
// in parallel and the exact major/minor score compare is a four-stage multiply pipeline.
// Words whose chroma sum is below min_total leave the pipeline with no result.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets min_total to 1.
module musical_key_estimator_unit #(
    parameter int CHROMA_BITS = mke_pkg::CHROMA_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [mke_pkg::FIELD_W-1:0]        i_chroma_c,
    input  logic [mke_pkg::FIELD_W-1:0]        i_chroma_cs,
    input  logic [mke_pkg::FIELD_W-1:0]        i_chroma_d,
    input  logic [mke_pkg::FIELD_W-1:0]        i_chroma_ds,
    input  logic [mke_pkg::FIELD_W-1:0]        i_chroma_e,
    input  logic [mke_pkg::FIELD_W-1:0]        i_chroma_f,
    input  logic [mke_pkg::FIELD_W-1:0]        i_chroma_fs,
    input  logic [mke_pkg::FIELD_W-1:0]        i_chroma_g,
    input  logic [mke_pkg::FIELD_W-1:0]        i_chroma_gs,
    input  logic [mke_pkg::FIELD_W-1:0]        i_chroma_a,
    input  logic [mke_pkg::FIELD_W-1:0]        i_chroma_as,
    input  logic [mke_pkg::FIELD_W-1:0]        i_chroma_b,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [mke_pkg::KEY_W-1:0]          o_key_index,
    output logic                               o_is_minor,
    output logic [mke_pkg::TONIC_W-1:0]        o_tonic_centihz,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int XB = (CHROMA_BITS < mke_pkg::FIELD_W) ? CHROMA_BITS : mke_pkg::FIELD_W;
    localparam int N = XB + mke_pkg::W_BITS;
    localparam int M = N - 1;
    localparam int TW = (XB + 4 > mke_pkg::CFG_W) ? XB + 4 : mke_pkg::CFG_W;
    localparam int OW = ((2*M + mke_pkg::PART_W - 1) / mke_pkg::PART_W) * mke_pkg::PART_W
                        + mke_pkg::K_W;
    localparam int NST = 9;

    logic [mke_pkg::CFG_W-1:0]   r_min_total;
    logic [NST-1:0]              r_v;
    logic [NST-1:0]              w_en;
    logic [XB-1:0]               w_in [mke_pkg::NPC];
    logic [XB-1:0]               r_x [mke_pkg::NPC];
    logic [TW-1:0]               w_total;
    logic                        w_pass;
    logic signed [N-1:0]         w_nmaj [mke_pkg::NPC];
    logic signed [N-1:0]         w_nmin [mke_pkg::NPC];
    logic signed [N-1:0]         w_bmaj;
    logic signed [N-1:0]         w_bmin;
    logic [mke_pkg::KEY_W-1:0]   w_imaj;
    logic [mke_pkg::KEY_W-1:0]   w_imin;
    logic [M-1:0]                w_mag_maj;
    logic [M-1:0]                w_mag_min;
    mke_pkg::t_meta              n_meta;
    mke_pkg::t_meta              r_meta [4];
    logic [OW-1:0]               w_a;
    logic [OW-1:0]               w_b;
    logic [1:0]                  w_rank_maj;
    logic [1:0]                  w_rank_min;
    logic                        w_min_gt;
    logic                        w_eq;
    logic                        w_pick_min;
    logic [mke_pkg::KEY_W-1:0]   w_key;
    logic [mke_pkg::KEY_W-1:0]   r_key;
    logic                        r_minor;
    logic [mke_pkg::TONIC_W-1:0] r_tonic;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mke_pkg::REG_MIN_TOTAL) ? 32'(r_min_total) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_total <= mke_pkg::CFG_W'(1);
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == mke_pkg::REG_MIN_TOTAL) begin
            r_min_total <= pwdata[mke_pkg::CFG_W-1:0];
        end
    end

    // A stage may load when it is empty or when the stage after it moves.
    always_comb begin
        w_en[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0] && w_pass;
            for (int k = 2; k < NST; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign w_in[0]  = i_chroma_c[XB-1:0];
    assign w_in[1]  = i_chroma_cs[XB-1:0];
    assign w_in[2]  = i_chroma_d[XB-1:0];
    assign w_in[3]  = i_chroma_ds[XB-1:0];
    assign w_in[4]  = i_chroma_e[XB-1:0];
    assign w_in[5]  = i_chroma_f[XB-1:0];
    assign w_in[6]  = i_chroma_fs[XB-1:0];
    assign w_in[7]  = i_chroma_g[XB-1:0];
    assign w_in[8]  = i_chroma_gs[XB-1:0];
    assign w_in[9]  = i_chroma_a[XB-1:0];
    assign w_in[10] = i_chroma_as[XB-1:0];
    assign w_in[11] = i_chroma_b[XB-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_x <= w_in;
        end
    end

    always_comb begin
        w_total = '0;
        for (int j = 0; j < mke_pkg::NPC; j++) begin
            w_total = w_total + TW'(r_x[j]);
        end
    end

    assign w_pass = w_total >= TW'(r_min_total);

    for (genvar r = 0; r < mke_pkg::NPC; r++) begin : g_lane
        mke_lane #(
            .XB  (XB),
            .N   (N),
            .ROT (r)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en[1]),
            .i_x    (r_x),
            .o_nmaj (w_nmaj[r]),
            .o_nmin (w_nmin[r])
        );
    end

    mke_merge #(
        .N (N)
    ) u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en[3:2]),
        .i_nmaj (w_nmaj),
        .i_nmin (w_nmin),
        .o_nmaj (w_bmaj),
        .o_nmin (w_bmin),
        .o_imaj (w_imaj),
        .o_imin (w_imin)
    );

    assign w_mag_maj = w_bmaj[N-1] ? M'(-w_bmaj) : M'(w_bmaj);
    assign w_mag_min = w_bmin[N-1] ? M'(-w_bmin) : M'(w_bmin);

    always_comb begin
        n_meta.idx_maj  = w_imaj;
        n_meta.idx_min  = w_imin;
        n_meta.neg_maj  = w_bmaj[N-1];
        n_meta.zero_maj = (w_bmaj == '0);
        n_meta.neg_min  = w_bmin[N-1];
        n_meta.zero_min = (w_bmin == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) r_meta[0] <= n_meta;
        for (int k = 1; k < 4; k++) begin
            if (w_en[4+k]) r_meta[k] <= r_meta[k-1];
        end
    end

    // Major score squared scaled by the minor weight energy, and the other way round.
    mke_sqk #(
        .M  (M),
        .K  (mke_pkg::K_MIN),
        .OW (OW)
    ) u_sqk_maj (
        .i_clk (i_clk),
        .i_en  (w_en[7:4]),
        .i_mag (w_mag_maj),
        .o_val (w_a)
    );

    mke_sqk #(
        .M  (M),
        .K  (mke_pkg::K_MAJ),
        .OW (OW)
    ) u_sqk_min (
        .i_clk (i_clk),
        .i_en  (w_en[7:4]),
        .i_mag (w_mag_min),
        .o_val (w_b)
    );

    // Rank by sign first: negative, zero, positive.
    assign w_rank_maj = r_meta[3].neg_maj ? 2'd0 : (r_meta[3].zero_maj ? 2'd1 : 2'd2);
    assign w_rank_min = r_meta[3].neg_min ? 2'd0 : (r_meta[3].zero_min ? 2'd1 : 2'd2);

    always_comb begin
        w_min_gt = 1'b0;
        w_eq = 1'b0;
        if (w_rank_min != w_rank_maj) begin
            w_min_gt = w_rank_min > w_rank_maj;
        end else if (w_rank_min == 2'd1) begin
            w_eq = 1'b1;
        end else begin
            w_eq = (w_a == w_b);
            w_min_gt = (w_rank_min == 2'd2) ? (w_b > w_a) : (w_b < w_a);
        end
    end

    // On equal scores the candidate visited first wins; major comes first in a rotation.
    assign w_pick_min = w_min_gt || (w_eq && r_meta[3].idx_min < r_meta[3].idx_maj);
    assign w_key = w_pick_min ? r_meta[3].idx_min : r_meta[3].idx_maj;

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_key   <= w_key;
            r_minor <= w_pick_min;
            r_tonic <= mke_pkg::f_tonic(w_key);
        end
    end

    assign o_valid         = r_v[NST-1];
    assign o_key_index     = r_key;
    assign o_is_minor      = r_minor;
    assign o_tonic_centihz = r_tonic;

endmodule

// ===== design/mke_chk.sv =====
`timescale 1ns / 1ps
module mke_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [mke_pkg::KEY_W-1:0]   o_key_index,
    input logic                        o_is_minor,
    input logic [mke_pkg::TONIC_W-1:0] o_tonic_centihz
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_key_index)
        && $stable(o_is_minor) && $stable(o_tonic_centihz))
        else $error("result word changed while stalled");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_key_index < 4'(mke_pkg::NPC))
        else $error("key index out of range");

    a_tonic_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_tonic_centihz == mke_pkg::f_tonic(o_key_index))
        else $error("tonic frequency does not match key");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output is empty");

endmodule

bind musical_key_estimator_unit mke_chk u_mke_chk (.*);
